FILE: rtl/acr_pkg.sv
package acr_pkg;

    localparam int unsigned ENTRIES_DEF = 16;
    localparam int unsigned OP_W        = 2;
    localparam int unsigned KEY_W       = 32;
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned SLOT_W      = 4;
    localparam int unsigned CNT_W       = 32;
    localparam int unsigned POLICY_W    = 2;
    localparam int unsigned LFSR_W      = 16;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;

    localparam logic [OP_W-1:0] OP_STORE  = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [POLICY_W-1:0] POL_LRU    = 2'd0;
    localparam logic [POLICY_W-1:0] POL_RANDOM = 2'd1;
    localparam logic [POLICY_W-1:0] POL_NONE   = 2'd2;

    typedef enum logic [3:0]
    {
        CMD_STORE  = 4'b0001,
        CMD_LOOKUP = 4'b0010,
        CMD_CLEAR  = 4'b0100,
        CMD_NOP    = 4'b1000
    } cmd_kind_t;

    typedef struct packed
    {
        cmd_kind_t         kind;
        logic [KEY_W-1:0]  key;
        logic [DATA_W-1:0] payload;
    } cmd_t;

endpackage

FILE: rtl/acr_if.sv
interface acr_in_if;
    logic                       valid;
    logic                       ready;
    logic [acr_pkg::OP_W-1:0]   op;
    logic [acr_pkg::KEY_W-1:0]  key;
    logic [acr_pkg::DATA_W-1:0] payload;

    modport source (output valid, output op, output key, output payload, input ready);
    modport sink   (input valid, input op, input key, input payload, output ready);
endinterface

interface acr_out_if;
    logic                       valid;
    logic                       ready;
    logic                       hit;
    logic [acr_pkg::DATA_W-1:0] data;
    logic [acr_pkg::SLOT_W-1:0] slot;
    logic                       stored;
    logic [acr_pkg::CNT_W-1:0]  hit_count;
    logic [acr_pkg::CNT_W-1:0]  miss_count;

    modport source (output valid, output hit, output data, output slot, output stored,
                    output hit_count, output miss_count, input ready);
    modport sink   (input valid, input hit, input data, input slot, input stored,
                    input hit_count, input miss_count, output ready);
endinterface

FILE: rtl/acr_front.sv
module acr_front
(
    input  logic          clk,
    input  logic          rst_n,
    acr_in_if.sink        req,
    output logic          q_valid,
    output acr_pkg::cmd_t q_cmd,
    input  logic          q_pop
);
    import acr_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_QW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    cmd_t               queue_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0]  count_reg, count_next;
    cmd_t               in_cmd;
    logic               push;

    always_comb
    begin
        in_cmd.key     = req.key;
        in_cmd.payload = req.payload;
        case (req.op)
            OP_STORE:  in_cmd.kind = CMD_STORE;
            OP_LOOKUP: in_cmd.kind = CMD_LOOKUP;
            OP_CLEAR:  in_cmd.kind = CMD_CLEAR;
            default:   in_cmd.kind = CMD_NOP;
        endcase
    end

    assign req.ready = (count_reg != CNT_QW'(QUEUE_DEPTH));
    assign push      = req.valid && req.ready;
    assign q_valid   = (count_reg != '0);
    assign q_cmd     = queue_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + CNT_QW'(1);
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - CNT_QW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_mem[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

FILE: rtl/acr_back.sv
module acr_back
#(
    parameter int unsigned ENTRIES = acr_pkg::ENTRIES_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  acr_pkg::cmd_t                  q_cmd,
    output logic                           q_pop,
    input  logic                           cfg_we,
    input  logic [acr_pkg::POLICY_W-1:0]   cfg_wdata,
    acr_out_if.source                      rsp
);
    import acr_pkg::*;

    localparam int unsigned IDX_W    = $clog2(ENTRIES);
    localparam int unsigned RECIP_SH = LFSR_W + IDX_W;
    localparam int unsigned RECIP_MW = LFSR_W + 1;
    localparam int unsigned PROD_W   = LFSR_W + RECIP_MW;
    localparam logic [IDX_W-1:0]    RANK_OLDEST = IDX_W'(ENTRIES - 1);
    localparam logic [RECIP_MW-1:0] RECIP_M     =
        RECIP_MW'(((64'd1 << RECIP_SH) + 64'(ENTRIES) - 64'd1) / 64'(ENTRIES));
    localparam logic [LFSR_W-1:0]   ENTRIES_L   = LFSR_W'(ENTRIES);

    typedef enum logic [5:0]
    {
        S_IDLE  = 6'b000001,
        S_EVAL  = 6'b000010,
        S_QUO   = 6'b000100,
        S_REM   = 6'b001000,
        S_WRITE = 6'b010000,
        S_READ  = 6'b100000
    } state_t;

    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
        logic fb;
        fb = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {fb, v[LFSR_W-1:1]};
    endfunction

    state_t              state_reg, state_next;
    cmd_t                cmd_reg;
    logic [POLICY_W-1:0] policy_reg;
    logic [ENTRIES-1:0]  occupied_reg;
    logic [KEY_W-1:0]    key_reg  [ENTRIES];
    logic [IDX_W-1:0]    rank_reg [ENTRIES];
    logic [DATA_W-1:0]   payload_mem [ENTRIES];
    logic [DATA_W-1:0]   rd_data_reg;
    logic [IDX_W-1:0]    target_reg;
    logic [LFSR_W-1:0]   lfsr_reg;
    logic [LFSR_W-1:0]   mod_val_reg;
    logic [LFSR_W-1:0]   quo_reg;
    logic [IDX_W-1:0]    rem_reg;
    logic [CNT_W-1:0]    hit_total_reg, miss_total_reg;

    logic                out_valid_reg, out_hit_reg, out_stored_reg;
    logic [DATA_W-1:0]   out_data_reg;
    logic [SLOT_W-1:0]   out_slot_reg;

    logic [ENTRIES-1:0]  match_vec, free_vec, oldest_vec;
    logic [IDX_W-1:0]    match_idx, free_idx, oldest_idx;
    logic                any_match, any_free, out_free;

    logic                store_en, clear_en, rd_en, mod_start, cnt_hit, cnt_miss;
    logic [IDX_W-1:0]    store_idx;
    logic                out_load, out_hit_next, out_stored_next;
    logic [DATA_W-1:0]   out_data_next;
    logic [SLOT_W-1:0]   out_slot_next;
    logic [PROD_W-1:0]   prod;
    logic [LFSR_W-1:0]   quo_next, rem_wide;
    logic                s_occ;
    logic [IDX_W-1:0]    s_rank;

    // tag compare and slot selection
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            match_vec[i]  = occupied_reg[i] && (key_reg[i] == cmd_reg.key);
            free_vec[i]   = !occupied_reg[i];
            oldest_vec[i] = (rank_reg[i] == RANK_OLDEST);
        end
        match_idx  = '0;
        oldest_idx = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match_vec[i])
            begin
                match_idx = IDX_W'(i);
            end
            if (oldest_vec[i])
            begin
                oldest_idx = IDX_W'(i);
            end
        end
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (free_vec[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign any_match = |match_vec;
    assign any_free  = |free_vec;
    assign out_free  = !out_valid_reg || rsp.ready;

    // victim = LFSR value mod ENTRIES: reciprocal multiply for the quotient, then remainder
    always_comb
    begin
        prod     = PROD_W'(mod_val_reg) * PROD_W'(RECIP_M);
        quo_next = LFSR_W'(prod >> RECIP_SH);
        rem_wide = mod_val_reg - quo_reg * ENTRIES_L;
    end

    always_comb
    begin
        state_next      = state_reg;
        q_pop           = 1'b0;
        store_en        = 1'b0;
        store_idx       = '0;
        clear_en        = 1'b0;
        rd_en           = 1'b0;
        mod_start       = 1'b0;
        cnt_hit         = 1'b0;
        cnt_miss        = 1'b0;
        out_load        = 1'b0;
        out_hit_next    = 1'b0;
        out_stored_next = 1'b0;
        out_data_next   = '0;
        out_slot_next   = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                    case (cmd_reg.kind)
                        CMD_STORE:
                        begin
                            if (any_free || policy_reg == POL_LRU)
                            begin
                                store_en        = 1'b1;
                                store_idx       = any_free ? free_idx : oldest_idx;
                                out_load        = 1'b1;
                                out_stored_next = 1'b1;
                                out_slot_next   = SLOT_W'(store_idx);
                            end
                            else if (policy_reg == POL_RANDOM)
                            begin
                                mod_start  = 1'b1;
                                state_next = S_QUO;
                            end
                            else
                            begin
                                out_load = 1'b1;
                            end
                        end
                        CMD_LOOKUP:
                        begin
                            if (any_match)
                            begin
                                rd_en      = 1'b1;
                                cnt_hit    = 1'b1;
                                state_next = S_READ;
                            end
                            else
                            begin
                                cnt_miss = 1'b1;
                                out_load = 1'b1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            clear_en = 1'b1;
                            out_load = 1'b1;
                        end
                        default:
                        begin
                            out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_QUO:
            begin
                state_next = S_REM;
            end
            S_REM:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (out_free)
                begin
                    store_en        = 1'b1;
                    store_idx       = rem_reg;
                    out_load        = 1'b1;
                    out_stored_next = 1'b1;
                    out_slot_next   = SLOT_W'(store_idx);
                    state_next      = S_IDLE;
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_hit_next  = 1'b1;
                    out_data_next = rd_data_reg;
                    out_slot_next = SLOT_W'(target_reg);
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign s_occ  = occupied_reg[store_idx];
    assign s_rank = rank_reg[store_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            policy_reg     <= POL_LRU;
            occupied_reg   <= '0;
            lfsr_reg       <= LFSR_SEED;
            hit_total_reg  <= '0;
            miss_total_reg <= '0;
            out_valid_reg  <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                policy_reg <= cfg_wdata;
            end
            if (cnt_hit)
            begin
                hit_total_reg <= hit_total_reg + CNT_W'(1);
            end
            if (cnt_miss)
            begin
                miss_total_reg <= miss_total_reg + CNT_W'(1);
            end
            if (mod_start)
            begin
                lfsr_reg <= lfsr_step(lfsr_reg);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (clear_en)
            begin
                occupied_reg <= '0;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    rank_reg[i] <= '0;
                end
            end
            else if (store_en)
            begin
                occupied_reg[store_idx] <= 1'b1;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (IDX_W'(i) == store_idx)
                    begin
                        rank_reg[i] <= '0;
                    end
                    else if (occupied_reg[i] && (!s_occ || rank_reg[i] < s_rank))
                    begin
                        rank_reg[i] <= rank_reg[i] + IDX_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_cmd;
        end
        if (store_en)
        begin
            key_reg[store_idx]     <= cmd_reg.key;
            payload_mem[store_idx] <= cmd_reg.payload;
        end
        if (rd_en)
        begin
            rd_data_reg <= payload_mem[match_idx];
            target_reg  <= match_idx;
        end
        if (mod_start)
        begin
            mod_val_reg <= lfsr_step(lfsr_reg);
        end
        if (state_reg == S_QUO)
        begin
            quo_reg <= quo_next;
        end
        if (state_reg == S_REM)
        begin
            rem_reg <= rem_wide[IDX_W-1:0];
        end
        if (out_load)
        begin
            out_hit_reg    <= out_hit_next;
            out_data_reg   <= out_data_next;
            out_slot_reg   <= out_slot_next;
            out_stored_reg <= out_stored_next;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.data       = out_data_reg;
    assign rsp.slot       = out_slot_reg;
    assign rsp.stored     = out_stored_reg;
    assign rsp.hit_count  = hit_total_reg;
    assign rsp.miss_count = miss_total_reg;

    a_store_occupies: assert property (@(posedge clk) disable iff (!rst_n)
        store_en |=> occupied_reg[$past(store_idx)])
        else $error("stored slot not marked occupied");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        clear_en |=> (occupied_reg == '0))
        else $error("clear left slots occupied");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_hit || cnt_miss) |=>
        ((hit_total_reg + miss_total_reg) == ($past(hit_total_reg + miss_total_reg) + 1)))
        else $error("lookup total did not advance by one");

    a_read_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> out_free)
        else $error("result register busy on lookup hit");

    a_oldest_unique: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_EVAL) && !any_free) |-> $onehot(oldest_vec))
        else $error("recency ranks not a permutation when full");

endmodule

FILE: rtl/assoc_cache_replacement_core.sv
// channel  | dir | beat fields
// ---------+-----+-------------------------------------------------------------
// req      | in  | op, key, payload
// rsp      | out | hit, data, slot, stored, hit_count, miss_count
// cfg      | in  | cfg_we, cfg_wdata (policy, no read-back)
//
// Store, clear, lookup miss pass IDLE and EVAL in the back end; lookup hit adds READ
// (payload RAM read). Store into a full cache under random policy adds QUO, REM, WRITE;
// LFSR value mod ENTRIES via reciprocal multiply: quotient in QUO, remainder in REM.
// A two-beat queue decouples req from the back end; rsp is a registered beat.
// Reset empties the cache, zeroes counters and ranks and seeds the LFSR; no clearing pass.
module assoc_cache_replacement_core
#(
    parameter int unsigned ENTRIES = acr_pkg::ENTRIES_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    acr_in_if.sink                       req,
    acr_out_if.source                    rsp,
    input  logic                         cfg_we,
    input  logic [acr_pkg::POLICY_W-1:0] cfg_wdata
);
    import acr_pkg::*;

    logic q_valid;
    logic q_pop;
    cmd_t q_cmd;

    acr_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_valid (q_valid),
        .q_cmd   (q_cmd),
        .q_pop   (q_pop)
    );

    acr_back
    #(
        .ENTRIES (ENTRIES)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .rsp       (rsp)
    );

endmodule
